@@ rtl/obbcp_pkg.sv @@
`timescale 1ns / 1ps
package obbcp_pkg;

  localparam int CW      = 20;   // Q12.8 coordinate / packed component width
  localparam int CFGW    = 60;   // configuration word
  localparam int IDXW    = 3;    // configuration index
  localparam int UW      = 18;   // unit axis component, signed Q.16 (|u| <= 1.0)
  localparam int SQW     = 64;   // square-root working width
  localparam int DIVW    = 48;   // division remainder width
  localparam int QW      = 17;   // quotient register width
  localparam int DENW    = 30;   // square-root result / divisor width
  localparam int NW      = 26;   // unnormalised normal component
  localparam int NRMW    = 16;   // Q1.14 normal
  localparam int CLW     = 25;   // closest point before saturation

  localparam int AX_ROOT_MSB = 56;  // top even bit of |row|^2 * 2^16
  localparam int AX_FRAC     = 24;
  localparam int AX_QBITS    = 17;
  localparam int N_FRAC      = 21;
  localparam int N_QBITS     = 16;
  localparam int N_ROOT_STG  = 16;  // two root bits per stage
  localparam int N_DIV_STG   = 8;   // two quotient bits per stage
  localparam int NRM_LAT     = N_ROOT_STG + N_DIV_STG + 4;
  localparam int CORE_LAT    = NRM_LAT + 8;

  typedef enum logic [IDXW-1:0] {
    REG_AXIS_X  = 3'd0,
    REG_AXIS_Y  = 3'd1,
    REG_AXIS_Z  = 3'd2,
    REG_CENTER  = 3'd3,
    REG_EXTENTS = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [SQW-1:0] v;
    logic [SQW-1:0] r;
  } sq_t;

  typedef struct packed {
    logic [DIVW-1:0] rem;
    logic [QW-1:0]   q;
  } div_t;

  // words carried alongside the normal datapath
  typedef struct packed {
    logic [2:0][CW-1:0] cl;
    logic               ins;
  } side_t;

  // one bit of the digit-by-digit integer square root
  function automatic sq_t sqrt_step(sq_t x, logic [SQW-1:0] b);
    sq_t y;
    if (x.v >= x.r + b) begin
      y.v = x.v - (x.r + b);
      y.r = (x.r >> 1) + b;
    end else begin
      y.v = x.v;
      y.r = x.r >> 1;
    end
    return y;
  endfunction

  // one restoring division step against a pre-shifted divisor
  function automatic div_t div_step(div_t x, logic [DIVW-1:0] dsh);
    div_t y;
    if (x.rem >= dsh) begin
      y.rem = x.rem - dsh;
      y.q   = {x.q[QW-2:0], 1'b1};
    end else begin
      y.rem = x.rem;
      y.q   = {x.q[QW-2:0], 1'b0};
    end
    return y;
  endfunction

endpackage

@@ rtl/obbcp_axis_norm.sv @@
`timescale 1ns / 1ps
module obbcp_axis_norm (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                go,
  input  logic [1:0]                          row_sel,
  input  logic [obbcp_pkg::CFGW-1:0]          row_data,
  output logic                                busy,
  output logic signed [obbcp_pkg::UW-1:0]     unit [3][3]
);
  import obbcp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SQ   = 5'b00010,
    ST_ROOT = 5'b00100,
    ST_LOAD = 5'b01000,
    ST_DIV  = 5'b10000
  } st_t;

  st_t                   state;
  logic [1:0]            row;
  logic [1:0]            comp;
  logic [4:0]            cnt;
  logic signed [CW-1:0]  a [3];
  logic [41:0]           len2;
  logic [41:0]           len2_next;
  sq_t                   sq;
  sq_t                   sq_next;
  logic [SQW-1:0]        bitv;
  logic [DENW-1:0]       den;
  div_t                  dv;
  div_t                  dv_next;
  logic signed [CW-1:0]  a_sq;
  logic signed [CW-1:0]  a_ld;
  logic [CW-1:0]         a_mag;
  logic signed [39:0]    sq_term;
  logic signed [UW-1:0]  res;

  always_comb begin
    a_sq      = a[cnt[1:0]];
    a_ld      = a[comp];
    sq_term   = 40'(a_sq) * 40'(a_sq);
    len2_next = len2 + 42'(sq_term);
    sq_next   = sqrt_step(sq, bitv);
    dv_next   = div_step(dv, DIVW'(den) << cnt);
    a_mag     = a_ld[CW-1] ? CW'(-a_ld) : CW'(a_ld);
    if (den == '0) begin
      res = '0;
    end else if (a_ld[CW-1]) begin
      res = -$signed({1'b0, dv_next.q});
    end else begin
      res = $signed({1'b0, dv_next.q});
    end
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          unit[i][j] <= '0;
        end
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (go) begin
            row   <= row_sel;
            for (int j = 0; j < 3; j++) begin
              a[j] <= row_data[CW*j +: CW];
            end
            cnt   <= '0;
            len2  <= '0;
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          len2 <= len2_next;
          if (cnt == 5'd2) begin
            sq.v  <= SQW'(len2_next) << 16;
            sq.r  <= '0;
            bitv  <= SQW'(1) << AX_ROOT_MSB;
            state <= ST_ROOT;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_ROOT: begin
          sq   <= sq_next;
          bitv <= bitv >> 2;
          if (bitv[0]) begin
            den   <= sq_next.r[DENW-1:0];
            comp  <= '0;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          dv.rem <= (DIVW'(a_mag) << AX_FRAC) + DIVW'(den >> 1);
          dv.q   <= '0;
          cnt    <= 5'(AX_QBITS - 1);
          state  <= ST_DIV;
        end
        ST_DIV: begin
          dv <= dv_next;
          if (cnt == '0) begin
            unit[row][comp] <= res;
            if (comp == 2'd2) begin
              state <= ST_IDLE;
            end else begin
              comp  <= comp + 2'd1;
              state <= ST_LOAD;
            end
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/obbcp_nrm_pipe.sv @@
`timescale 1ns / 1ps
module obbcp_nrm_pipe (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_vld,
  input  logic signed [obbcp_pkg::NW-1:0]     n_in [3],
  input  obbcp_pkg::side_t                    side_in,
  output logic                                out_vld,
  output logic signed [obbcp_pkg::NRMW-1:0]   nrm_out [3],
  output obbcp_pkg::side_t                    side_out
);
  import obbcp_pkg::*;

  // squares
  logic                  v0;
  logic signed [NW-1:0]  n0 [3];
  logic [47:0]           sq0 [3];
  side_t                 sd0;
  logic signed [2*NW-1:0] sqp [3];

  // root stages
  logic                  vr   [N_ROOT_STG+1];
  sq_t                   sqs  [N_ROOT_STG+1];
  logic signed [NW-1:0]  nr   [N_ROOT_STG+1][3];
  side_t                 sdr  [N_ROOT_STG+1];

  // division stages
  logic                  vd   [N_DIV_STG+1];
  div_t                  dd   [N_DIV_STG+1][3];
  logic [DENW-1:0]       dend [N_DIV_STG+1];
  logic [2:0]            negd [N_DIV_STG+1];
  side_t                 sdd  [N_DIV_STG+1];

  logic [NW-2:0]         nmag [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sqp[j]  = (2*NW)'(n_in[j]) * (2*NW)'(n_in[j]);
      nmag[j] = nr[N_ROOT_STG][j][NW-1] ? (NW-1)'(-nr[N_ROOT_STG][j])
                                        : (NW-1)'(nr[N_ROOT_STG][j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0; else v0 <= in_vld;
    for (int j = 0; j < 3; j++) begin
      n0[j]  <= n_in[j];
      sq0[j] <= sqp[j][47:0];
    end
    sd0 <= side_in;
  end

  always_ff @(posedge clk) begin
    if (rst) vr[0] <= 1'b0; else vr[0] <= v0;
    sqs[0].v <= SQW'(sq0[0] + sq0[1] + sq0[2]) << 14;
    sqs[0].r <= '0;
    nr[0]    <= n0;
    sdr[0]   <= sd0;
  end

  for (genvar g = 0; g < N_ROOT_STG; g++) begin : g_root
    always_ff @(posedge clk) begin
      if (rst) vr[g+1] <= 1'b0; else vr[g+1] <= vr[g];
      sqs[g+1] <= sqrt_step(sqrt_step(sqs[g], SQW'(1) << (62 - 4*g)),
                            SQW'(1) << (60 - 4*g));
      nr[g+1]  <= nr[g];
      sdr[g+1] <= sdr[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vd[0] <= 1'b0; else vd[0] <= vr[N_ROOT_STG];
    for (int j = 0; j < 3; j++) begin
      dd[0][j].rem <= (DIVW'(nmag[j]) << N_FRAC)
                      + DIVW'(sqs[N_ROOT_STG].r[DENW-1:0] >> 1);
      dd[0][j].q   <= '0;
      negd[0][j]   <= nr[N_ROOT_STG][j][NW-1];
    end
    dend[0] <= sqs[N_ROOT_STG].r[DENW-1:0];
    sdd[0]  <= sdr[N_ROOT_STG];
  end

  for (genvar g = 0; g < N_DIV_STG; g++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) vd[g+1] <= 1'b0; else vd[g+1] <= vd[g];
      for (int j = 0; j < 3; j++) begin
        dd[g+1][j] <= div_step(div_step(dd[g][j],
                                        DIVW'(dend[g]) << (N_QBITS - 1 - 2*g)),
                               DIVW'(dend[g]) << (N_QBITS - 2 - 2*g));
      end
      dend[g+1] <= dend[g];
      negd[g+1] <= negd[g];
      sdd[g+1]  <= sdd[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0; else out_vld <= vd[N_DIV_STG];
    for (int j = 0; j < 3; j++) begin
      if (dend[N_DIV_STG] == '0) begin
        nrm_out[j] <= '0;
      end else if (negd[N_DIV_STG][j]) begin
        nrm_out[j] <= -$signed(dd[N_DIV_STG][j].q[NRMW-1:0]);
      end else begin
        nrm_out[j] <= $signed(dd[N_DIV_STG][j].q[NRMW-1:0]);
      end
    end
    side_out <= sdd[N_DIV_STG];
  end

endmodule

@@ rtl/obb_closest_point_and_normal_core.sv @@
`timescale 1ns / 1ps
// channel   | handshake                | payload
// ----------+--------------------------+-------------------------------------------
// query     | start in, busy out       | point_x/y/z (Q12.8)
// result    | done out (one-cycle)     | closest_x/y/z, normal_x/y/z, inside_res
// config    | cfg_valid in, cfg_ready  | cfg_index, cfg_data (60-bit word)
//
// One query word per cycle while busy is low; each result passes through the
// normal's square root (16 stages, two root bits each) and divider (8 stages,
// two quotient bits each) plus 12 projection/setup stages.
// Writing an axis row starts a serial normaliser; busy and !cfg_ready hold
// during it. Reset (rst, synchronous) clears the centre and extents registers,
// unit axes and pipeline valids. The result side cannot stall.
module obb_closest_point_and_normal_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [obbcp_pkg::CW-1:0]     point_x,
  input  logic signed [obbcp_pkg::CW-1:0]     point_y,
  input  logic signed [obbcp_pkg::CW-1:0]     point_z,
  output logic                                done,
  output logic signed [obbcp_pkg::CW-1:0]     closest_x,
  output logic signed [obbcp_pkg::CW-1:0]     closest_y,
  output logic signed [obbcp_pkg::CW-1:0]     closest_z,
  output logic signed [obbcp_pkg::NRMW-1:0]   normal_x,
  output logic signed [obbcp_pkg::NRMW-1:0]   normal_y,
  output logic signed [obbcp_pkg::NRMW-1:0]   normal_z,
  output logic                                inside_res,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [obbcp_pkg::IDXW-1:0]          cfg_index,
  input  logic [obbcp_pkg::CFGW-1:0]          cfg_data
);
  import obbcp_pkg::*;

  logic [CFGW-1:0]       box_center;
  logic [CFGW-1:0]       box_extents;
  logic                  eng_busy;
  logic                  cfg_we;
  logic                  axis_go;
  logic signed [UW-1:0]  unit [3][3];
  logic signed [CW-1:0]  ctr [3];
  logic [CW-1:0]         ext [3];
  logic                  accept;
  logic [7:0]            vld;   // stage valids, query taken into bit 0

  assign cfg_ready = !eng_busy;
  assign busy      = eng_busy;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign accept    = start && !busy;

  always_comb begin
    case (reg_idx_t'(cfg_index))
      REG_AXIS_X, REG_AXIS_Y, REG_AXIS_Z: axis_go = cfg_we;
      default:                            axis_go = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_center  <= '0;
      box_extents <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_CENTER:  box_center  <= cfg_data;
        REG_EXTENTS: box_extents <= cfg_data;
        default: ;
      endcase
    end
  end

  // unit axes are kept up to date by a serial sqrt/divide unit
  obbcp_axis_norm u_axis (
    .clk      (clk),
    .rst      (rst),
    .go       (axis_go),
    .row_sel  (cfg_index[1:0]),
    .row_data (cfg_data),
    .busy     (eng_busy),
    .unit     (unit)
  );

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ctr[j] = box_center[CW*j +: CW];
      ext[j] = box_extents[CW*j +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= {vld[6:0], accept};
  end

  // A: point capture
  logic signed [CW-1:0] pt_a [3];
  always_ff @(posedge clk) begin
    pt_a[0] <= point_x;
    pt_a[1] <= point_y;
    pt_a[2] <= point_z;
  end

  // B: offset from centre
  logic signed [CW:0]   d_b [3];
  logic signed [CW-1:0] pt_b [3];
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      d_b[j] <= (CW+1)'(pt_a[j]) - (CW+1)'(ctr[j]);
    end
    pt_b <= pt_a;
  end

  // C: projection products u[i][j] * d[j]
  logic signed [38:0]   prod_c [3][3];
  logic signed [CW-1:0] pt_c [3];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_c[i][j] <= 39'(unit[i][j]) * 39'(d_b[j]);
      end
    end
    pt_c <= pt_b;
  end

  // D: sum, round half up to Q.8, clamp, per-axis depth
  logic signed [40:0]   acc_d [3];
  logic signed [24:0]   pr_d [3];
  logic signed [24:0]   ext_s [3];
  logic signed [21:0]   pcl_d [3];
  logic [CW:0]          pabs_d [3];
  logic [2:0]           in_d;
  logic signed [21:0]   p_d [3];
  logic [CW-1:0]        dep_d [3];
  logic [2:0]           ins_d;
  logic signed [CW-1:0] pt_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_d[i] = 41'(prod_c[i][0]) + 41'(prod_c[i][1]) + 41'(prod_c[i][2]);
      pr_d[i]  = 25'((acc_d[i] + 41'sd32768) >>> 16);
      ext_s[i] = $signed({5'b0, ext[i]});
      if (pr_d[i] > ext_s[i])       pcl_d[i] = 22'(ext_s[i]);
      else if (pr_d[i] < -ext_s[i]) pcl_d[i] = 22'(-ext_s[i]);
      else                          pcl_d[i] = 22'(pr_d[i]);
      in_d[i]   = (pr_d[i] < ext_s[i]) && (pr_d[i] > -ext_s[i]);
      pabs_d[i] = pcl_d[i][21] ? (CW+1)'(-pcl_d[i]) : (CW+1)'(pcl_d[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p_d[i]   <= pcl_d[i];
      dep_d[i] <= CW'((CW+1)'(ext[i]) - pabs_d[i]);
    end
    ins_d <= in_d;
    pt_d  <= pt_c;
  end

  // E: face snap when strictly inside; x wins ties, then z before y
  logic signed [21:0]   p_e [3];
  logic signed [21:0]   p_snap [3];
  logic [1:0]           face;
  logic                 ins_e;
  logic signed [CW-1:0] pt_e [3];

  always_comb begin
    if (dep_d[0] <= dep_d[1] && dep_d[0] <= dep_d[2]) face = 2'd0;
    else if (dep_d[2] <= dep_d[1])                     face = 2'd2;
    else                                               face = 2'd1;
    p_snap = p_d;
    if (&ins_d) begin
      p_snap[face] = p_d[face][21] ? -$signed({2'b0, ext[face]})
                                   : $signed({2'b0, ext[face]});
    end
  end

  always_ff @(posedge clk) begin
    p_e   <= p_snap;
    ins_e <= &ins_d;
    pt_e  <= pt_d;
  end

  // F: back-projection products p[i] * u[i][j]
  logic signed [39:0]   prod_f [3][3];
  logic                 ins_f;
  logic signed [CW-1:0] pt_f [3];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_f[i][j] <= 40'(p_e[i]) * 40'(unit[i][j]);
      end
    end
    ins_f <= ins_e;
    pt_f  <= pt_e;
  end

  // G: closest point at full width
  logic signed [41:0]    acc_g [3];
  logic signed [23:0]    off_g [3];
  logic signed [CLW-1:0] cl_g [3];
  logic                  ins_g;
  logic signed [CW-1:0]  pt_g [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc_g[j] = 42'(prod_f[0][j]) + 42'(prod_f[1][j]) + 42'(prod_f[2][j]);
      off_g[j] = 24'((acc_g[j] + 42'sd32768) >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      cl_g[j] <= CLW'(ctr[j]) + CLW'(off_g[j]);
    end
    ins_g <= ins_f;
    pt_g  <= pt_f;
  end

  // H: normal direction and saturated closest point
  logic signed [NW-1:0] n_h [3];
  side_t                side_h;
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      if (ins_g) n_h[j] <= NW'(cl_g[j]) - NW'(pt_g[j]);
      else       n_h[j] <= NW'(pt_g[j]) - NW'(cl_g[j]);
      if (cl_g[j] > CLW'(524287))       side_h.cl[j] <= CW'(524287);
      else if (cl_g[j] < -CLW'(524288)) side_h.cl[j] <= CW'(524288);
      else                              side_h.cl[j] <= CW'(cl_g[j]);
    end
    side_h.ins <= ins_g;
  end

  logic signed [NRMW-1:0] nrm [3];
  side_t                  side_o;

  obbcp_nrm_pipe u_nrm (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (vld[7]),
    .n_in     (n_h),
    .side_in  (side_h),
    .out_vld  (done),
    .nrm_out  (nrm),
    .side_out (side_o)
  );

  assign closest_x  = side_o.cl[0];
  assign closest_y  = side_o.cl[1];
  assign closest_z  = side_o.cl[2];
  assign normal_x   = nrm[0];
  assign normal_y   = nrm[1];
  assign normal_z   = nrm[2];
  assign inside_res = side_o.ins;

endmodule

@@ rtl/obbcp_checker.sv @@
`timescale 1ns / 1ps
module obbcp_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic                                done,
  input logic                                cfg_ready,
  input logic signed [obbcp_pkg::NRMW-1:0]   normal_x,
  input logic signed [obbcp_pkg::NRMW-1:0]   normal_y,
  input logic signed [obbcp_pkg::NRMW-1:0]   normal_z
);
  import obbcp_pkg::*;

  // every taken query returns after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##CORE_LAT done)
    else $error("result missing after query");

  // no result without a query taken earlier
  a_no_spurious: assert property (@(posedge clk)
    done |-> $past(start && !busy && !rst, CORE_LAT))
    else $error("result without query");

  // config port closed exactly while axes are renormalised
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_ready != busy)
    else $error("cfg_ready and busy disagree");

  // normal components stay within unit range
  a_nrm_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (normal_x <= 16'sd16384 && normal_x >= -16'sd16384 &&
              normal_y <= 16'sd16384 && normal_y >= -16'sd16384 &&
              normal_z <= 16'sd16384 && normal_z >= -16'sd16384))
    else $error("normal out of range");

endmodule

bind obb_closest_point_and_normal_core obbcp_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .cfg_ready (cfg_ready),
  .normal_x  (normal_x),
  .normal_y  (normal_y),
  .normal_z  (normal_z)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import obbcp_pkg::*;

  localparam int PERIOD     = 12;
  localparam int WDOG_LIMIT = 4000;  // idle cycles allowed

  logic clk, rst;
  logic start, busy, done, inside_res;
  logic signed [CW-1:0] point_x, point_y, point_z;
  logic signed [CW-1:0] closest_x, closest_y, closest_z;
  logic signed [NRMW-1:0] normal_x, normal_y, normal_z;
  logic cfg_valid, cfg_ready;
  logic [IDXW-1:0] cfg_index;
  logic [CFGW-1:0] cfg_data;

  obb_closest_point_and_normal_core dut (.*);

  typedef struct {
    logic signed [CW-1:0]   cx, cy, cz;
    logic signed [NRMW-1:0] nx, ny, nz;
    logic                   ins;
  } contact_t;

  contact_t contact_q[$];
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int inside_seen = 0;
  int idle_cycles = 0;
  bit calm = 0;  // when set, the sender never idles

  // predictor's copy of the registers
  logic [CFGW-1:0] row_reg[3];
  logic [CFGW-1:0] centre_reg, extent_reg;

  initial begin
    clk = 0;
    forever #(PERIOD / 2) clk = ~clk;
  end

  // watchdog: counts cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("%0t watchdog expired, %0d contacts outstanding", $time, contact_q.size());
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  function automatic longint comp20(logic [CFGW-1:0] r, int k);
    logic signed [CW-1:0] f;
    f = r[20*k +: 20];
    return longint'(f);
  endfunction

  function automatic longint isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // round to nearest of v / 2^16, halves up
  function automatic longint rnd16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic longint div_away(longint num, longint den);
    longint m, q;
    m = num < 0 ? -num : num;
    q = (m + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  // v * 2^k / floor(sqrt(|v|^2 * 2^pre)); zero vector stays zero
  function automatic void scale_unit(input longint v[3], input int pre, input int k,
                                     output longint o[3]);
    longint unsigned l2;
    longint s;
    l2 = 0;
    for (int i = 0; i < 3; i++) l2 += longint'(v[i] * v[i]);
    s = isqrt(l2 << pre);
    for (int i = 0; i < 3; i++) o[i] = s != 0 ? div_away(v[i] <<< k, s) : 0;
  endfunction

  function automatic logic signed [CW-1:0] clip20(longint v);
    if (v > 524287) return 20'sd524287;
    if (v < -524288) return -20'sd524288;
    return v[CW-1:0];
  endfunction

  function automatic contact_t closest_contact(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                                               logic signed [CW-1:0] pz);
    contact_t c;
    longint u[3][3], raw[3], tmp[3], ctr[3], ext[3], pt[3], d[3], p[3], cl[3], n[3], nu[3];
    longint dep[3], acc;
    bit ins;
    int f;
    pt[0] = px; pt[1] = py; pt[2] = pz;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) raw[j] = comp20(row_reg[i], j);
      scale_unit(raw, 16, 24, tmp);
      for (int j = 0; j < 3; j++) u[i][j] = tmp[j];
      ctr[i] = comp20(centre_reg, i);
      ext[i] = longint'(extent_reg[20*i +: 20]);
      d[i] = pt[i] - ctr[i];
    end
    ins = 1;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += u[i][j] * d[j];
      p[i] = rnd16(acc);
      if (p[i] > ext[i]) p[i] = ext[i];
      if (p[i] < -ext[i]) p[i] = -ext[i];
      if (!(p[i] < ext[i] && p[i] > -ext[i])) ins = 0;
      dep[i] = ext[i] - (p[i] < 0 ? -p[i] : p[i]);
    end
    if (ins) begin
      // nearest face; ties favour x, then z over y
      if (dep[0] <= dep[1] && dep[0] <= dep[2]) f = 0;
      else if (dep[2] <= dep[1]) f = 2;
      else f = 1;
      p[f] = p[f] < 0 ? -ext[f] : ext[f];
    end
    for (int j = 0; j < 3; j++) begin
      acc = 0;
      for (int i = 0; i < 3; i++) acc += p[i] * u[i][j];
      cl[j] = ctr[j] + rnd16(acc);
      n[j] = ins ? cl[j] - pt[j] : pt[j] - cl[j];
    end
    scale_unit(n, 14, 21, nu);
    c.cx = clip20(cl[0]); c.cy = clip20(cl[1]); c.cz = clip20(cl[2]);
    c.nx = nu[0][NRMW-1:0]; c.ny = nu[1][NRMW-1:0]; c.nz = nu[2][NRMW-1:0];
    c.ins = ins;
    return c;
  endfunction

  // result checker
  always @(posedge clk) begin
    contact_t e;
    if (!rst && done) begin
      results_seen++;
      if (contact_q.size() == 0) begin
        errors++;
        $display("%0t unexpected contact: closest %0d %0d %0d", $time,
                 closest_x, closest_y, closest_z);
      end else begin
        e = contact_q.pop_front();
        if (inside_res) inside_seen++;
        if (closest_x !== e.cx || closest_y !== e.cy || closest_z !== e.cz) begin
          errors++;
          $display("%0t closest mismatch: expected %0d %0d %0d, actual %0d %0d %0d", $time,
                   e.cx, e.cy, e.cz, closest_x, closest_y, closest_z);
        end
        if (normal_x !== e.nx || normal_y !== e.ny || normal_z !== e.nz) begin
          errors++;
          $display("%0t normal mismatch: expected %0d %0d %0d, actual %0d %0d %0d", $time,
                   e.nx, e.ny, e.nz, normal_x, normal_y, normal_z);
        end
        if (inside_res !== e.ins) begin
          errors++;
          $display("%0t inside mismatch: expected %0b, actual %0b", $time, e.ins, inside_res);
        end
      end
    end
  end

  // one query word; prediction uses the registers as they stand.
  // start stays high on return so words can follow back to back; whoever
  // comes next lowers it at the same falling edge.
  task automatic send_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                            logic signed [CW-1:0] z);
    while (!calm && $urandom_range(99) < 37) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1;
    point_x <= x; point_y <= y; point_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    contact_q.push_back(closest_contact(x, y, z));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFGW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_AXIS_X: row_reg[0] = val;
      REG_AXIS_Y: row_reg[1] = val;
      REG_AXIS_Z: row_reg[2] = val;
      REG_CENTER: centre_reg = val;
      REG_EXTENTS: extent_reg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    start <= 0;
    while (contact_q.size() != 0) @(negedge clk);
    repeat (CORE_LAT + 4) @(negedge clk);
  endtask

  function automatic logic [CFGW-1:0] pack3(int a, int b, int c);
    logic [19:0] fa, fb, fc;
    fa = a[19:0]; fb = b[19:0]; fc = c[19:0];
    return {fc, fb, fa};
  endfunction

  function automatic logic signed [CW-1:0] rnd_coord();
    case ($urandom_range(3))
      0: return CW'($urandom);  // full range, saturation territory
      default: return CW'($urandom_range(8191) - 4096);
    endcase
  endfunction

  task automatic setup_box(logic [CFGW-1:0] ax, logic [CFGW-1:0] ay, logic [CFGW-1:0] az,
                           logic [CFGW-1:0] ctr, logic [CFGW-1:0] ext);
    drain();
    write_reg(REG_AXIS_X, ax);
    write_reg(REG_AXIS_Y, ay);
    write_reg(REG_AXIS_Z, az);
    write_reg(REG_CENTER, ctr);
    write_reg(REG_EXTENTS, ext);
  endtask

  // reset registers: every axis zero, so closest is the centre
  task automatic test_reset_box();
    send_point(20'sd0, 20'sd0, 20'sd0);
    send_point(20'sd524287, -20'sd524288, 20'sd100);
  endtask

  // unit box, field extremes, face ties, snap directions, zero normal
  task automatic test_directed();
    setup_box(pack3(65536, 0, 0), pack3(0, 65536, 0), pack3(0, 0, 65536),
              pack3(0, 0, 0), pack3(2560, 2560, 2560));
    send_point(20'sd0, 20'sd0, 20'sd0);            // all depths tie: x face, plus side
    send_point(20'sd0, -20'sd100, 20'sd0);         // y nearest, negative snap; x and z tie
    send_point(-20'sd100, -20'sd100, -20'sd50);    // x and y tie: x face, negative snap
    send_point(20'sd10, -20'sd2000, 20'sd5);       // y nearest, negative snap
    send_point(20'sd2560, 20'sd0, 20'sd0);         // on the face: zero normal
    send_point(20'sd5000, 20'sd6000, -20'sd7000);  // corner, outside
    send_point(20'sd524287, 20'sd524287, 20'sd524287);
    send_point(-20'sd524288, -20'sd524288, -20'sd524288);
    send_point(20'sd524287, -20'sd524288, 20'sd0);
    // one zero extent: never inside
    setup_box(pack3(65536, 0, 0), pack3(0, 65536, 0), pack3(0, 0, 65536),
              pack3(0, 0, 0), pack3(2560, 0, 2560));
    send_point(20'sd0, 20'sd0, 20'sd0);
    send_point(20'sd100, 20'sd0, -20'sd100);
    // extreme registers: centre and extents at their limits, one zero axis
    setup_box(pack3(-524288, -524288, -524288), pack3(0, 0, 0),
              pack3(524287, 524287, 524287), pack3(524287, -524288, 524287),
              {3{20'hFFFFF}});
    send_point(20'sd0, 20'sd0, 20'sd0);
    send_point(-20'sd524288, 20'sd524287, 20'sd1);
    send_point(20'sd524287, 20'sd524287, -20'sd524288);
    setup_box(pack3(1, 0, 0), pack3(0, -1, 0), pack3(0, 0, 1),
              pack3(-524288, 524287, 0), pack3(1, 1, 1));
    send_point(-20'sd524288, 20'sd524287, 20'sd0);
    send_point(20'sd0, 20'sd0, 20'sd0);
  endtask

  // random boxes with mostly-bounded coordinates
  task automatic test_random();
    int unsigned ang;
    for (int b = 0; b < 34; b++) begin
      if (b % 6 == 5) begin
        setup_box(CFGW'({$urandom, $urandom}), CFGW'({$urandom, $urandom}),
                  CFGW'({$urandom, $urandom}), CFGW'({$urandom, $urandom}),
                  CFGW'({$urandom, $urandom}));
      end else begin
        ang = $urandom_range(3);
        setup_box(pack3($urandom_range(131071) - 65536, $urandom_range(8191) - 4096, 0),
                  pack3($urandom_range(8191) - 4096, $urandom_range(131071) - 65536,
                        ang == 0 ? 0 : $urandom_range(8191) - 4096),
                  pack3(0, $urandom_range(511), $urandom_range(65536) + 1000),
                  pack3($urandom_range(4095) - 2048, $urandom_range(4095) - 2048,
                        $urandom_range(4095) - 2048),
                  pack3($urandom_range(3000), $urandom_range(3000), $urandom_range(3000)));
      end
      calm = (b >= 14 && b < 18);
      for (int i = 0; i < 50; i++) send_point(rnd_coord(), rnd_coord(), rnd_coord());
    end
    calm = 0;
  endtask

  initial begin
    rst = 1;
    start = 0;
    point_x = 0; point_y = 0; point_z = 0;
    cfg_valid = 0; cfg_index = REG_AXIS_X; cfg_data = 0;
    for (int i = 0; i < 3; i++) row_reg[i] = 0;
    centre_reg = 0;
    extent_reg = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_reset_box();
    test_directed();
    test_random();
    drain();
    $display("covered %0d query words, %0d contacts checked (%0d inside)",
             words_sent, results_seen, inside_seen);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
